// ===== src/dltq_pkg.sv =====
// ----------------------------------------------------------------------------
// dltq_pkg: shared types and constants of the delta-list timer queue
// Command codes, status codes, queue depth and the front-to-back word.
// ----------------------------------------------------------------------------
`default_nettype none
package dltq_pkg;
  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [0:0] {CMD_INSERT = 1'b0, CMD_DELETE = 1'b1} cmd_t;
  typedef enum logic [1:0] {
    ST_DONE = 2'd0, ST_FULL = 2'd1, ST_EMPTY = 2'd2, ST_RSVD = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t        command;
    logic [15:0] delay;
    logic [7:0]  sem_id;
    logic        periodic;
  } cmd_word_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SHIFT, S_PLACE, S_DEL, S_REPLY
  } eng_state_t;
endpackage
`default_nettype wire

// ===== src/dltq_front.sv =====
// ----------------------------------------------------------------------------
// dltq_front: command intake
// Unpacks the input word and holds up to two commands for the engine.
// ----------------------------------------------------------------------------
`default_nettype none
module dltq_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [25:0]         in_bits,
  output logic                     q_valid,
  input  wire logic                q_ready,
  output dltq_pkg::cmd_word_t      q_word
);
  dltq_pkg::cmd_word_t slot [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] fill;
  dltq_pkg::cmd_word_t in_word;

  // tdata: command[0], delay[16:1], sem_id[24:17], periodic[25]
  always_comb begin
    in_word.command  = dltq_pkg::cmd_t'(in_bits[0]);
    in_word.delay    = in_bits[16:1];
    in_word.sem_id   = in_bits[24:17];
    in_word.periodic = in_bits[25];
  end

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_word   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) slot[wr_ptr] <= in_word;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= ~wr_ptr;
      if (q_valid && q_ready) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'((in_valid && in_ready) ? 1 : 0)
                   - 2'((q_valid && q_ready) ? 1 : 0);
    end
  end

  a_fill_max: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue overfill");
  a_no_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd0) |-> !q_valid) else $error("pop from empty queue");
  a_fill_track: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !(q_valid && q_ready)) |=> fill == $past(fill) + 2'd1)
    else $error("fill mismatch");
endmodule
`default_nettype wire

// ===== src/dltq_engine.sv =====
// ----------------------------------------------------------------------------
// dltq_engine: queue storage and command execution
// Walks the delta list one entry a cycle to insert or delete, then replies.
// ----------------------------------------------------------------------------
`default_nettype none
module dltq_engine (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  output logic                     q_ready,
  input  dltq_pkg::cmd_word_t      q_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [30:0]              out_bits
);
  localparam int unsigned IW = dltq_pkg::IDX_W;
  localparam int unsigned CW = dltq_pkg::CNT_W;

  logic [15:0] e_delta [dltq_pkg::DEPTH];
  logic [7:0]  e_id    [dltq_pkg::DEPTH];
  logic        e_per   [dltq_pkg::DEPTH];
  logic [15:0] e_init  [dltq_pkg::DEPTH];

  dltq_pkg::eng_state_t state, state_next;
  dltq_pkg::cmd_word_t  cmd;
  logic [CW-1:0] count, pos, ptr, wr;
  logic [16:0]   acc, carry;
  logic [1:0]    status;
  logic [IW-1:0] pi, wi;
  logic [16:0]   sum;

  assign pi  = ptr[IW-1:0];
  assign wi  = wr[IW-1:0];
  assign sum = acc + {1'b0, e_delta[pi]};

  always_comb begin
    state_next = state;
    case (state)
      dltq_pkg::S_IDLE:
        if (q_valid) begin
          if (q_word.command == dltq_pkg::CMD_INSERT)
            state_next = (count == CW'(dltq_pkg::DEPTH)) ? dltq_pkg::S_REPLY
                                                         : dltq_pkg::S_SCAN;
          else
            state_next = (count == '0) ? dltq_pkg::S_REPLY : dltq_pkg::S_DEL;
        end
      dltq_pkg::S_SCAN:
        if (ptr == count || {1'b0, cmd.delay} <= sum) state_next = dltq_pkg::S_SHIFT;
      dltq_pkg::S_SHIFT: if (ptr == pos) state_next = dltq_pkg::S_PLACE;
      dltq_pkg::S_PLACE: state_next = dltq_pkg::S_REPLY;
      dltq_pkg::S_DEL:   if (ptr == count) state_next = dltq_pkg::S_REPLY;
      dltq_pkg::S_REPLY: if (out_ready) state_next = dltq_pkg::S_IDLE;
      default: state_next = dltq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    q_ready   = (state == dltq_pkg::S_IDLE);
    out_valid = (state == dltq_pkg::S_REPLY);
  end

  // tdata: status[1:0], entry_count[6:2], head_id[14:7], head_delta[30:15]
  assign out_bits = {(count != '0) ? e_delta[0] : 16'd0,
                     (count != '0) ? e_id[0] : 8'd0, 5'(count), status};

  always_ff @(posedge clk) begin
    case (state)
      dltq_pkg::S_IDLE: begin
        cmd <= q_word; acc <= '0; carry <= '0; ptr <= '0; wr <= '0;
        status <= (q_word.command == dltq_pkg::CMD_INSERT && count == CW'(dltq_pkg::DEPTH))
                  ? dltq_pkg::ST_FULL
                  : (q_word.command == dltq_pkg::CMD_DELETE && count == '0)
                  ? dltq_pkg::ST_EMPTY : dltq_pkg::ST_DONE;
      end
      dltq_pkg::S_SCAN:
        if (ptr == count || {1'b0, cmd.delay} <= sum) begin
          pos <= ptr; ptr <= count;
          if (ptr != count) e_delta[pi] <= 16'(sum - {1'b0, cmd.delay});
        end else begin
          acc <= sum; ptr <= ptr + 1'b1;
        end
      dltq_pkg::S_SHIFT:
        if (ptr != pos) begin
          e_delta[pi] <= e_delta[IW'(ptr - 1'b1)];
          e_id[pi]    <= e_id[IW'(ptr - 1'b1)];
          e_per[pi]   <= e_per[IW'(ptr - 1'b1)];
          e_init[pi]  <= e_init[IW'(ptr - 1'b1)];
          ptr <= ptr - 1'b1;
        end
      dltq_pkg::S_PLACE: begin
        e_delta[pos[IW-1:0]] <= 16'({1'b0, cmd.delay} - acc);
        e_id[pos[IW-1:0]]    <= cmd.sem_id;
        e_per[pos[IW-1:0]]   <= cmd.periodic;
        e_init[pos[IW-1:0]]  <= cmd.delay;
      end
      dltq_pkg::S_DEL:
        if (ptr != count) begin
          ptr <= ptr + 1'b1;
          if (e_id[pi] == cmd.sem_id) carry <= carry + {1'b0, e_delta[pi]};
          else begin
            e_delta[wi] <= e_delta[pi] + carry[15:0];
            e_id[wi]    <= e_id[pi];
            e_per[wi]   <= e_per[pi];
            e_init[wi]  <= e_init[pi];
            carry <= '0; wr <= wr + 1'b1;
          end
        end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dltq_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == dltq_pkg::S_PLACE) count <= count + 1'b1;
      if (state == dltq_pkg::S_DEL && ptr == count) count <= wr;
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(dltq_pkg::DEPTH)) else $error("count overflow");
  a_one_reply: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> !out_valid) else $error("double reply");
  a_no_grow_del: assert property (@(posedge clk) disable iff (rst)
    (state == dltq_pkg::S_DEL) |=> count <= $past(count)) else $error("delete grew");
  a_wr_le_ptr: assert property (@(posedge clk) disable iff (rst)
    (state == dltq_pkg::S_DEL) |-> wr <= ptr) else $error("write passed read");
endmodule
`default_nettype wire

// ===== src/delta_list_timer_queue.sv =====
// ----------------------------------------------------------------------------
// delta_list_timer_queue: sorted delta-encoded timer queue
// Top level joining the command intake and the list engine.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command word (insert or delete by id); m_axis returns
//   one status word per command: status, entry count, head id and delta.
//   The intake buffers two commands, so a new word is taken while the engine
//   works or while a reply waits.
//   A word is registered in the intake before it reaches the engine. Insert
//   scans to the slot, then shifts the tail one entry a cycle; delete
//   makes one pass compacting the list. Full-queue and empty-delete
//   replies skip the walk. The engine takes a new command only after the
//   reply to the last one is taken.
//   Reset empties the queue and drops buffered commands.
//   When m_axis stalls the reply holds; the engine waits and intake fills.
// ----------------------------------------------------------------------------
`default_nettype none
module delta_list_timer_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // command, delay, sem_id, periodic
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata   // status, entry_count, head_id, head_delta
);
  logic                q_valid, q_ready;
  dltq_pkg::cmd_word_t q_word;
  logic [30:0]         res;

  dltq_front u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_bits(s_axis_tdata[25:0]), .q_valid, .q_ready, .q_word);

  dltq_engine u_engine (
    .clk, .rst, .q_valid, .q_ready, .q_word,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_bits(res));

  assign m_axis_tdata = {1'b0, res};
endmodule
`default_nettype wire
